FILE: sv/amd2_pkg.sv
package amd2_pkg;

	localparam int MAX_NODES_DEF = 16;
	localparam int VAL_W = 24;
	localparam int RES_W = 25;
	localparam int DIF_W = 26;
	localparam int W_W = 17;
	localparam int IT_W = 16;
	localparam int SUM_W = 64;
	localparam int PRD_W = 52;
	localparam int SOL_W = 31;
	localparam int MAG_W = 62;
	localparam int LAM_W = 32;
	localparam int QDEPTH = 4;
	localparam int NSUMS = 5;
	localparam int NPRODS = 6;

	localparam logic signed [LAM_W-1:0] HALF_Q16 = 32'sd32768;
	localparam logic [LAM_W-1:0] LAM_MAX = 32'h7FFF_FFFF;
	localparam logic [IT_W-1:0] ITER_SOLVE = 16'd2;

	typedef struct packed {
		logic [VAL_W-1:0] new_value;
		logic [VAL_W-1:0] target;
		logic [W_W-1:0] weight;
		logic [IT_W-1:0] iteration;
		logic last;
		logic store;
	} item_t;

endpackage

FILE: sv/anderson_mixing_depth_two.sv
// Loading a stored element takes one memory read, then five products through one shared
// multiplier, each weighted and accumulated. A request queue of four entries in front lets
// requests arrive while the back end works. On a last request with iteration two or more the
// solve takes up to 33 normalising shifts, six products and up to two 78-step serial
// divisions. An asynchronous reset clears all sums, counts and history valid bits at once.
module anderson_mixing_depth_two #(
	parameter int MAX_NODES = amd2_pkg::MAX_NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [amd2_pkg::VAL_W-1:0] new_value,
	input  logic signed [amd2_pkg::VAL_W-1:0] target,
	input  logic [amd2_pkg::W_W-1:0]          weight,
	input  logic [amd2_pkg::IT_W-1:0]         iteration,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [amd2_pkg::VAL_W-1:0] new_target,
	output logic                              singular,
	output logic                              last_out
);
	import amd2_pkg::*;

	logic q_valid;
	logic q_pop;
	item_t q_item;

	amd2_front #(.MAX_NODES(MAX_NODES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.new_value(new_value), .target(target), .weight(weight),
		.iteration(iteration), .last(last),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	amd2_back #(.MAX_NODES(MAX_NODES)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready), .new_target(new_target),
		.singular(singular), .last_out(last_out)
	);

endmodule

FILE: sv/amd2_ram.sv
module amd2_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/amd2_front.sv
module amd2_front #(
	parameter int MAX_NODES = amd2_pkg::MAX_NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [amd2_pkg::VAL_W-1:0] new_value,
	input  logic signed [amd2_pkg::VAL_W-1:0] target,
	input  logic [amd2_pkg::W_W-1:0]          weight,
	input  logic [amd2_pkg::IT_W-1:0]         iteration,
	input  logic                              last,
	output logic                              q_valid,
	output amd2_pkg::item_t                   q_item,
	input  logic                              q_pop
);
	import amd2_pkg::*;

	localparam int CAP = 3 * MAX_NODES;
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int PTR_W = $clog2(QDEPTH);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);
	localparam logic [PTR_W:0] FULL_C = (PTR_W + 1)'(QDEPTH);

	item_t fifo_q [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0] fill_q;
	logic [CNT_W-1:0] cnt_q;
	logic push;
	logic store;

	assign in_ready = (fill_q != FULL_C);
	assign push = in_valid && in_ready;
	assign store = (cnt_q < CAP_C);
	assign q_valid = (fill_q != '0);
	assign q_item = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
				if (last) begin
					cnt_q <= '0;
				end else if (store) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && q_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{new_value: new_value, target: target, weight: weight,
				iteration: iteration, last: last, store: store};
		end
	end

endmodule

FILE: sv/amd2_div.sv
module amd2_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [amd2_pkg::MAG_W-1:0]   num,
	input  logic [amd2_pkg::MAG_W-1:0]   den,
	output logic                         done,
	output logic [amd2_pkg::LAM_W-1:0]   quo
);
	import amd2_pkg::*;

	localparam int DVD_W = MAG_W + 16;
	localparam int STP_W = $clog2(DVD_W + 1);

	logic busy_q;
	logic done_q;
	logic [STP_W-1:0] step_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] den_q;
	logic [DVD_W-1:0] dvd_q;
	logic [LAM_W-2:0] quo_q;
	logic ovf_q;
	logic [MAG_W:0] trial;
	logic [MAG_W:0] diff;
	logic ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge = (trial >= {1'b0, den_q});
	assign diff = trial - {1'b0, den_q};
	assign done = done_q;
	assign quo = ovf_q ? LAM_MAX : {1'b0, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, 16'b0};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
			quo_q <= {quo_q[LAM_W-3:0], ge};
			ovf_q <= ovf_q | quo_q[LAM_W-2];
		end
	end

endmodule

FILE: sv/amd2_back.sv
module amd2_back #(
	parameter int MAX_NODES = amd2_pkg::MAX_NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  amd2_pkg::item_t                   q_item,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [amd2_pkg::VAL_W-1:0] new_target,
	output logic                              singular,
	output logic                              last_out
);
	import amd2_pkg::*;

	localparam int CAP = 3 * MAX_NODES;
	localparam int IDX_W = $clog2(CAP);
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int HW = VAL_W + RES_W;
	localparam int WP_W = PRD_W + W_W + 1;
	localparam int P_W = LAM_W + RES_W;
	localparam int ACC_W = 59;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);

	typedef enum logic [4:0] {
		ST_IDLE, ST_LRD, ST_LMUL, ST_LWGT, ST_LACC,
		ST_SHIFT, ST_SMUL, ST_SDET, ST_DIV1, ST_DIV1W, ST_DIV2, ST_DIV2W,
		ST_ERD, ST_EDIF, ST_EM1, ST_EM2, ST_EOUT
	} state_t;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b
	);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return s[SUM_W-1:0];
	endfunction

	function automatic logic fits(input logic [SUM_W-1:0] x);
		return (&x[SUM_W-1:SOL_W-1]) || !(|x[SUM_W-1:SOL_W-1]);
	endfunction

	state_t state_q;
	item_t item_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0] j_q;
	logic [IDX_W-1:0] i_q;
	logic signed [SUM_W-1:0] sums_q [NSUMS];
	logic signed [DIF_W-1:0] f0_q, f1_q, r_q;
	logic signed [PRD_W-1:0] prod_q;
	logic signed [SUM_W-1:0] wp_q;
	logic signed [MAG_W-1:0] sp_q [NPRODS];
	logic signed [SUM_W-1:0] det_q, n1_q, n2_q;
	logic signed [LAM_W-1:0] l1_q, l2_q;
	logic sing_q;
	logic signed [VAL_W-1:0] cv_q;
	logic signed [RES_W-1:0] d1_q, d2_q;
	logic signed [P_W-1:0] p1_q, p2_q;
	logic [CAP-1:0] prev_vld_q, older_vld_q;
	logic out_valid_q;
	logic signed [VAL_W-1:0] new_target_q;
	logic singular_q, last_out_q;

	logic [IDX_W-1:0] cnt_idx, rd_addr, use_addr;
	logic [HW-1:0] cur_rd, prev_rd, older_rd, prev_eff, older_eff;
	logic signed [VAL_W-1:0] pv, ov, v_in, t_in;
	logic signed [RES_W-1:0] pr, orr, r_now;
	logic signed [DIF_W-1:0] ma, mb;
	logic signed [SOL_W-1:0] sa, sb;
	logic signed [WP_W-1:0] wfull;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-17:0] yfull;
	logic signed [VAL_W-1:0] y_sat;
	logic out_free;
	logic div_start, div_done;
	logic [MAG_W-1:0] div_num, div_den;
	logic [LAM_W-1:0] div_quo;
	logic signed [SUM_W-1:0] det_abs, n1_abs, n2_abs;

	assign cnt_idx = cnt_q[IDX_W-1:0];
	assign rd_addr = (state_q == ST_ERD) ? i_q : cnt_idx;
	assign use_addr = (state_q == ST_EDIF) ? i_q : cnt_idx;
	assign prev_eff = prev_vld_q[use_addr] ? prev_rd : '0;
	assign older_eff = older_vld_q[use_addr] ? older_rd : '0;
	assign pv = $signed(prev_eff[HW-1 -: VAL_W]);
	assign pr = $signed(prev_eff[RES_W-1:0]);
	assign ov = $signed(older_eff[HW-1 -: VAL_W]);
	assign orr = $signed(older_eff[RES_W-1:0]);
	assign v_in = $signed(item_q.new_value);
	assign t_in = $signed(item_q.target);
	assign r_now = RES_W'(v_in) - RES_W'(t_in);

	amd2_ram #(.WIDTH(HW), .DEPTH(CAP)) u_cur_ram (
		.clk(clk), .we((state_q == ST_LRD) && item_q.store), .waddr(cnt_idx),
		.wdata({v_in, r_now}), .raddr(i_q), .rdata(cur_rd)
	);

	amd2_ram #(.WIDTH(HW), .DEPTH(CAP)) u_prev_ram (
		.clk(clk), .we(state_q == ST_EDIF), .waddr(i_q),
		.wdata(cur_rd), .raddr(rd_addr), .rdata(prev_rd)
	);

	amd2_ram #(.WIDTH(HW), .DEPTH(CAP)) u_older_ram (
		.clk(clk), .we(state_q == ST_EDIF), .waddr(i_q),
		.wdata(prev_eff), .raddr(rd_addr), .rdata(older_rd)
	);

	always_comb begin
		case (j_q)
			3'd0: begin ma = f0_q; mb = f0_q; end
			3'd1: begin ma = f0_q; mb = f1_q; end
			3'd2: begin ma = f1_q; mb = f1_q; end
			3'd3: begin ma = f0_q; mb = r_q; end
			default: begin ma = f1_q; mb = r_q; end
		endcase
	end

	always_comb begin
		case (j_q)
			3'd0: begin sa = sums_q[0][SOL_W-1:0]; sb = sums_q[2][SOL_W-1:0]; end
			3'd1: begin sa = sums_q[1][SOL_W-1:0]; sb = sums_q[1][SOL_W-1:0]; end
			3'd2: begin sa = sums_q[2][SOL_W-1:0]; sb = sums_q[3][SOL_W-1:0]; end
			3'd3: begin sa = sums_q[1][SOL_W-1:0]; sb = sums_q[4][SOL_W-1:0]; end
			3'd4: begin sa = sums_q[0][SOL_W-1:0]; sb = sums_q[4][SOL_W-1:0]; end
			default: begin sa = sums_q[1][SOL_W-1:0]; sb = sums_q[3][SOL_W-1:0]; end
		endcase
	end

	assign wfull = WP_W'(prod_q) * WP_W'($signed({1'b0, item_q.weight}));

	assign acc = (ACC_W'(cv_q) <<< 16) - ACC_W'(p1_q) - ACC_W'(p2_q);
	assign yfull = (ACC_W-16)'((acc + ACC_W'(HALF_Q16)) >>> 16);
	always_comb begin
		if (yfull > (ACC_W-16)'($signed({1'b0, {(VAL_W-1){1'b1}}}))) begin
			y_sat = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (yfull < (ACC_W-16)'($signed({1'b1, {(VAL_W-1){1'b0}}}))) begin
			y_sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			y_sat = yfull[VAL_W-1:0];
		end
	end

	assign det_abs = det_q[SUM_W-1] ? -det_q : det_q;
	assign n1_abs = n1_q[SUM_W-1] ? -n1_q : n1_q;
	assign n2_abs = n2_q[SUM_W-1] ? -n2_q : n2_q;
	assign div_start = ((state_q == ST_DIV1) && (det_q != '0)) || (state_q == ST_DIV2);
	assign div_num = (state_q == ST_DIV2) ? n2_abs[MAG_W-1:0] : n1_abs[MAG_W-1:0];
	assign div_den = det_abs[MAG_W-1:0];

	amd2_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign new_target = new_target_q;
	assign singular = singular_q;
	assign last_out = last_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			j_q <= '0;
			i_q <= '0;
			sing_q <= 1'b0;
			prev_vld_q <= '0;
			older_vld_q <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NSUMS; k++) begin
				sums_q[k] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_EOUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.store) begin
							state_q <= ST_LRD;
						end else if (q_item.last) begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_LRD: begin
					j_q <= '0;
					state_q <= ST_LMUL;
				end
				ST_LMUL: state_q <= ST_LWGT;
				ST_LWGT: state_q <= ST_LACC;
				ST_LACC: begin
					sums_q[j_q] <= sat_add(sums_q[j_q], wp_q);
					if (j_q == 3'(NSUMS - 1)) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= item_q.last ? ST_SHIFT : ST_IDLE;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= ST_LMUL;
					end
				end
				ST_SHIFT: begin
					sing_q <= 1'b0;
					if (item_q.iteration < ITER_SOLVE) begin
						i_q <= '0;
						state_q <= ST_ERD;
					end else if (fits(sums_q[0]) && fits(sums_q[1]) && fits(sums_q[2])
						&& fits(sums_q[3]) && fits(sums_q[4])) begin
						j_q <= '0;
						state_q <= ST_SMUL;
					end else begin
						for (int k = 0; k < NSUMS; k++) begin
							sums_q[k] <= sums_q[k] >>> 1;
						end
					end
				end
				ST_SMUL: begin
					if (j_q == 3'(NPRODS - 1)) begin
						state_q <= ST_SDET;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_SDET: state_q <= ST_DIV1;
				ST_DIV1: begin
					if (det_q == '0) begin
						sing_q <= 1'b1;
						i_q <= '0;
						state_q <= ST_ERD;
					end else begin
						state_q <= ST_DIV1W;
					end
				end
				ST_DIV1W: begin
					if (div_done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: state_q <= ST_DIV2W;
				ST_DIV2W: begin
					if (div_done) begin
						i_q <= '0;
						state_q <= ST_ERD;
					end
				end
				ST_ERD: state_q <= ST_EDIF;
				ST_EDIF: begin
					prev_vld_q[i_q] <= 1'b1;
					older_vld_q[i_q] <= 1'b1;
					state_q <= ST_EM1;
				end
				ST_EM1: state_q <= ST_EM2;
				ST_EM2: state_q <= ST_EOUT;
				ST_EOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (i_q == IDX_W'(cnt_q - 1'b1)) begin
							cnt_q <= '0;
							for (int k = 0; k < NSUMS; k++) begin
								sums_q[k] <= '0;
							end
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= ST_ERD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_LRD) begin
			r_q <= DIF_W'(r_now);
			f0_q <= DIF_W'(r_now) - DIF_W'(pr);
			f1_q <= DIF_W'(pr) - DIF_W'(orr);
		end
		if (state_q == ST_LMUL) begin
			prod_q <= PRD_W'(ma) * PRD_W'(mb);
		end
		if (state_q == ST_LWGT) begin
			wp_q <= SUM_W'($signed(wfull[WP_W-1:16]));
		end
		if (state_q == ST_SMUL) begin
			sp_q[j_q] <= MAG_W'(sa) * MAG_W'(sb);
		end
		if (state_q == ST_SDET) begin
			det_q <= SUM_W'(sp_q[0]) - SUM_W'(sp_q[1]);
			n1_q <= SUM_W'(sp_q[2]) - SUM_W'(sp_q[3]);
			n2_q <= SUM_W'(sp_q[4]) - SUM_W'(sp_q[5]);
		end
		if ((state_q == ST_SHIFT && item_q.iteration < ITER_SOLVE)
			|| (state_q == ST_DIV1 && det_q == '0)) begin
			l1_q <= HALF_Q16;
			l2_q <= HALF_Q16;
		end
		if (state_q == ST_DIV1W && div_done) begin
			l1_q <= (n1_q[SUM_W-1] ^ det_q[SUM_W-1]) ? -$signed(div_quo) : $signed(div_quo);
		end
		if (state_q == ST_DIV2W && div_done) begin
			l2_q <= (n2_q[SUM_W-1] ^ det_q[SUM_W-1]) ? -$signed(div_quo) : $signed(div_quo);
		end
		if (state_q == ST_EDIF) begin
			cv_q <= $signed(cur_rd[HW-1 -: VAL_W]);
			d1_q <= RES_W'($signed(cur_rd[HW-1 -: VAL_W])) - RES_W'(pv);
			d2_q <= RES_W'(pv) - RES_W'(ov);
		end
		if (state_q == ST_EM1) begin
			p1_q <= P_W'(l1_q) * P_W'(d1_q);
		end
		if (state_q == ST_EM2) begin
			p2_q <= P_W'(l2_q) * P_W'(d2_q);
		end
		if (state_q == ST_EOUT && out_free) begin
			new_target_q <= y_sat;
			singular_q <= sing_q;
			last_out_q <= (i_q == IDX_W'(cnt_q - 1'b1));
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CAP_C)
		else $error("Element count exceeds the store capacity.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EOUT) |-> ({1'b0, i_q} < (IDX_W + 1)'(cnt_q)))
		else $error("Emission index runs past the stored elements.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1W) |-> (det_q != '0))
		else $error("Division started with a zero determinant.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EOUT && sing_q) |-> (det_q == '0))
		else $error("Singular flag raised with a non-zero determinant.");

endmodule

FILE: bench/tb_anderson_mixing_depth_two.sv
module tb_anderson_mixing_depth_two;
	timeunit 1ns;
	timeprecision 1ps;

	import amd2_pkg::*;

	localparam int NODES = MAX_NODES_DEF;
	localparam int CAP = 3 * NODES;
	localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint SUM_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
	localparam longint LIMIT_CYCLES = 4000000;

	typedef struct packed {
		logic [VAL_W-1:0] new_value;
		logic [VAL_W-1:0] target;
		logic [W_W-1:0] weight;
		logic [IT_W-1:0] iteration;
		logic last;
	} request_t;

	typedef struct packed {
		logic [VAL_W-1:0] new_target;
		logic singular;
		logic last_out;
	} mixed_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [VAL_W-1:0] new_value = '0;
	logic signed [VAL_W-1:0] target = '0;
	logic [W_W-1:0] weight = '0;
	logic [IT_W-1:0] iteration = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [VAL_W-1:0] new_target;
	logic singular;
	logic last_out;

	request_t pending_requests[$];
	mixed_t expected_targets[$];
	int errors = 0;
	int drain_pause = 0;
	int accepted = 0;
	bit in_taken = 0;
	bit out_taken = 0;
	bit stimulus_done = 0;
	longint cycle_count = 0;

	longint sweep_values[CAP];
	longint sweep_residuals[CAP];
	longint hist_values[CAP];
	longint hist_values_old[CAP];
	longint hist_residuals[CAP];
	longint hist_residuals_old[CAP];
	longint normal_acc[5];
	int sweep_count = 0;

	anderson_mixing_depth_two i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.new_value(new_value), .target(target), .weight(weight),
		.iteration(iteration), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_target(new_target), .singular(singular), .last_out(last_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint add_saturated(longint a, longint b);
		if (b > 0 && a > SUM_MAX - b)
			return SUM_MAX;
		if (b < 0 && a < SUM_MIN - b)
			return SUM_MIN;
		return a + b;
	endfunction

	function automatic longint apply_weight(longint p, longint w);
		longint hi;
		longint lo;
		hi = p >>> 16;
		lo = p - hi * 65536;
		return hi * w + ((lo * w) >>> 16);
	endfunction

	function automatic longint factor_quotient(longint num, longint den);
		bit neg;
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] q;
		neg = (num < 0) != (den < 0);
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		q = n / d;
		if (q >= 32768)
			q = 64'h7FFF_FFFF;
		else
			q = 64'(({16'h0, n} << 16) / {16'h0, d});
		return neg ? -longint'(q) : longint'(q);
	endfunction

	task automatic predict_mixing(request_t rq);
		longint v, t, w, r, f0, f1, l1, l2, det, cv, d1, d2, acc, y;
		longint m[5];
		bit fits;
		bit sing;
		v = longint'(signed'(rq.new_value));
		t = longint'(signed'(rq.target));
		w = longint'(rq.weight);
		l1 = 32768;
		l2 = 32768;
		sing = 0;
		if (sweep_count < CAP) begin
			r = v - t;
			f0 = r - hist_residuals[sweep_count];
			f1 = hist_residuals[sweep_count] - hist_residuals_old[sweep_count];
			sweep_values[sweep_count] = v;
			sweep_residuals[sweep_count] = r;
			normal_acc[0] = add_saturated(normal_acc[0], apply_weight(f0 * f0, w));
			normal_acc[1] = add_saturated(normal_acc[1], apply_weight(f0 * f1, w));
			normal_acc[2] = add_saturated(normal_acc[2], apply_weight(f1 * f1, w));
			normal_acc[3] = add_saturated(normal_acc[3], apply_weight(f0 * r, w));
			normal_acc[4] = add_saturated(normal_acc[4], apply_weight(f1 * r, w));
			sweep_count++;
		end
		if (!rq.last)
			return;
		if (rq.iteration >= ITER_SOLVE) begin
			for (int s = 0; s < 64; s++) begin
				fits = 1;
				for (int i = 0; i < 5; i++) begin
					m[i] = floor_shift(normal_acc[i], s);
					if (m[i] >= (64'sd1 << 30) || m[i] < -(64'sd1 << 30))
						fits = 0;
				end
				if (fits)
					break;
			end
			det = m[0] * m[2] - m[1] * m[1];
			if (det == 0) begin
				sing = 1;
			end else begin
				l1 = factor_quotient(m[2] * m[3] - m[1] * m[4], det);
				l2 = factor_quotient(m[0] * m[4] - m[1] * m[3], det);
			end
		end
		for (int i = 0; i < sweep_count; i++) begin
			cv = sweep_values[i];
			d1 = cv - hist_values[i];
			d2 = hist_values[i] - hist_values_old[i];
			acc = cv * 65536 - l1 * d1 - l2 * d2;
			y = (acc + 32768) >>> 16;
			if (y > 8388607)
				y = 8388607;
			if (y < -8388608)
				y = -8388608;
			expected_targets.push_back('{new_target: y[VAL_W-1:0], singular: sing,
				last_out: (i + 1 == sweep_count)});
			hist_values_old[i] = hist_values[i];
			hist_values[i] = cv;
			hist_residuals_old[i] = hist_residuals[i];
			hist_residuals[i] = sweep_residuals[i];
		end
		for (int i = 0; i < 5; i++)
			normal_acc[i] = 0;
		sweep_count = 0;
	endtask

	function automatic logic [VAL_W-1:0] random_value();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return VAL_W'($urandom_range(0, 4000) - 2000);
			default: return VAL_W'($urandom);
		endcase
	endfunction

	task automatic queue_sweep(int len, int iter, bit extreme);
		request_t rq;
		for (int i = 0; i < len; i++) begin
			rq.new_value = extreme ? (i[0] ? 24'h7FFFFF : 24'h800000) : random_value();
			rq.target = extreme ? (i[0] ? 24'h800000 : 24'h7FFFFF) : random_value();
			case ($urandom_range(0, 3))
				0: rq.weight = 17'd65536;
				1: rq.weight = 17'd0;
				default: rq.weight = W_W'($urandom_range(0, 65536));
			endcase
			rq.iteration = (i == len - 1) ? IT_W'(iter) : IT_W'($urandom);
			rq.last = (i == len - 1);
			pending_requests.push_back(rq);
		end
	endtask

	initial begin
		int sent;
		int len;
		for (int i = 0; i < CAP; i++) begin
			hist_values[i] = 0;
			hist_values_old[i] = 0;
			hist_residuals[i] = 0;
			hist_residuals_old[i] = 0;
		end
		for (int i = 0; i < 5; i++)
			normal_acc[i] = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		queue_sweep(1, 0, 0);
		queue_sweep(3, 1, 1);
		queue_sweep(3, 2, 1);
		queue_sweep(3, 65535, 0);
		queue_sweep(2, 2, 0);
		queue_sweep(1, 5, 0);
		queue_sweep(CAP + 3, 7, 0);
		queue_sweep(4, 3, 0);
		sent = pending_requests.size();
		while (sent < 500) begin
			if ($urandom_range(0, 19) == 0)
				len = $urandom_range(1, CAP + 4);
			else
				len = $urandom_range(1, 6);
			queue_sweep(len, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1)
				: $urandom_range(2, 65535), $urandom_range(0, 15) == 0);
			sent += len;
		end
		wait (pending_requests.size() == 0 && !in_valid);
		stimulus_done = 1;
	end

	always @(negedge clk) begin
		static int in_gap = 0;
		static int out_gap = 0;
		request_t rq;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (drain_pause == 1 && expected_targets.size() != 0) begin
					in_valid <= 1'b0;
				end else if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap--;
				end else if (pending_requests.size() > 0) begin
					if (drain_pause == 1)
						drain_pause = 2;
					rq = pending_requests.pop_front();
					new_value <= rq.new_value;
					target <= rq.target;
					weight <= rq.weight;
					iteration <= rq.iteration;
					last <= rq.last;
					in_valid <= 1'b1;
					in_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (out_taken)
				out_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
			if (out_gap > 0) begin
				out_ready <= 1'b0;
				out_gap--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		mixed_t want;
		cycle_count <= cycle_count + 1;
		in_taken = arst_n && in_valid && in_ready;
		out_taken = arst_n && out_valid && out_ready;
		if (in_taken) begin
			predict_mixing('{new_value, target, weight, iteration, last});
			accepted++;
			if (last && accepted > 250 && drain_pause == 0)
				drain_pause = 1;
		end
		if (out_taken) begin
			if (expected_targets.size() == 0) begin
				$display("%0t: unexpected result new_target=%0d", $time, new_target);
				errors++;
			end else begin
				want = expected_targets.pop_front();
				if (new_target !== want.new_target) begin
					$display("%0t: new_target expected %0d actual %0d", $time,
						signed'(want.new_target), new_target);
					errors++;
				end
				if (singular !== want.singular) begin
					$display("%0t: singular expected %0b actual %0b", $time,
						want.singular, singular);
					errors++;
				end
				if (last_out !== want.last_out) begin
					$display("%0t: last_out expected %0b actual %0b", $time,
						want.last_out, last_out);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (stimulus_done && expected_targets.size() == 0);
		repeat (400) @(posedge clk);
		if (errors == 0 && expected_targets.size() == 0)
			$display("anderson_mixing_depth_two test passed");
		else
			$display("anderson_mixing_depth_two test failed");
		$finish;
	end

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("%0t: timeout", $time);
		$display("anderson_mixing_depth_two test failed");
		$finish;
	end
endmodule

FILE: anderson_mixing_depth_two.f
sv/amd2_pkg.sv
sv/amd2_ram.sv
sv/amd2_front.sv
sv/amd2_div.sv
sv/amd2_back.sv
sv/anderson_mixing_depth_two.sv
bench/tb_anderson_mixing_depth_two.sv
